// ===== sv/rlis_pkg.sv =====
// Package for the rotary limit impulse solver: controller state type and
// the command/status structs that join controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rlis_pkg;

    localparam int unsigned OP_PRESTEP = 0;
    localparam int unsigned OP_IMPULSE = 1;

    localparam logic [2:0] CFG_MIN_ANGLE = 3'd0;
    localparam logic [2:0] CFG_MAX_ANGLE = 3'd1;
    localparam logic [2:0] CFG_BIAS_COEF = 3'd2;
    localparam logic [2:0] CFG_MAX_BIAS  = 3'd3;
    localparam logic [2:0] CFG_MAX_FORCE = 3'd4;

    // datapath micro steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_DIST,    // dist, pdist, start divider, k product
        ST_PRE_K,       // saturate k, start k*pdist
        ST_PRE_BIAS,    // clamp bias, start max_force*dt
        ST_PRE_LIMIT,   // store limit, clear acc if bias zero
        ST_DIV_WAIT,    // wait for reciprocal
        ST_IT_WR,       // wr, (bias+wr) product
        ST_IT_J,        // j, clamp accumulated impulse
        ST_VEL_A,       // j*im_a
        ST_VEL_B,       // j*im_b
        ST_OUT
    } t_state;

    typedef struct packed {
        logic   load;
        t_state step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic prestep;
        logic skip;
    } t_status;

endpackage

// ===== sv/rotary_limit_impulse_solver.sv =====
// Rotary limit impulse solver, Q(32-FRAC_BITS).FRAC_BITS fixed point.
// An impulse item skips the impulse and velocity steps when bias is zero; a prestep
// waits in ST_DIV_WAIT for the bit-serial reciprocal divider.
// One item at a time; next item accepted in the cycle after the result beat is taken.
// Synchronous active-low reset clears state and loads register defaults.
`timescale 1ns / 1ps

module rotary_limit_impulse_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic signed [31:0] i_angle_a,
    input  logic signed [31:0] i_angle_b,
    input  logic [30:0]        i_inv_moment_a,
    input  logic [30:0]        i_inv_moment_b,
    input  logic signed [31:0] i_ang_vel_a,
    input  logic signed [31:0] i_ang_vel_b,
    input  logic [30:0]        i_time_step,
    input  logic [30:0]        i_inv_time_step,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_ang_vel_a,
    output logic signed [31:0] o_new_ang_vel_b,
    output logic [30:0]        o_impulse_magnitude
);
    import rlis_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rlis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rlis_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_operation         (i_operation),
        .i_angle_a           (i_angle_a),
        .i_angle_b           (i_angle_b),
        .i_inv_moment_a      (i_inv_moment_a),
        .i_inv_moment_b      (i_inv_moment_b),
        .i_ang_vel_a         (i_ang_vel_a),
        .i_ang_vel_b         (i_ang_vel_b),
        .i_time_step         (i_time_step),
        .i_inv_time_step     (i_inv_time_step),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_new_ang_vel_a     (o_new_ang_vel_a),
        .o_new_ang_vel_b     (o_new_ang_vel_b),
        .o_impulse_magnitude (o_impulse_magnitude)
    );

endmodule

// ===== sv/rlis_ctrl.sv =====
// Controller state machine of the rotary limit impulse solver.
// Depends on rlis_pkg.
`timescale 1ns / 1ps

module rlis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  rlis_pkg::t_status i_status,
    output rlis_pkg::t_cmd    o_cmd
);
    import rlis_pkg::*;

    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.prestep ? ST_PRE_DIST : ST_IT_WR;
                end
            end
            ST_PRE_DIST:  n_state = ST_PRE_K;
            ST_PRE_K:     n_state = ST_PRE_BIAS;
            ST_PRE_BIAS:  n_state = ST_PRE_LIMIT;
            ST_PRE_LIMIT: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (i_status.div_done) n_state = ST_VEL_A;
            ST_IT_WR:     n_state = i_status.skip ? ST_OUT : ST_IT_J;
            ST_IT_J:      n_state = ST_VEL_A;
            ST_VEL_A:     n_state = ST_VEL_B;
            ST_VEL_B:     n_state = ST_OUT;
            ST_OUT:       if (!i_stall) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall    = (r_state != ST_IDLE);
        o_valid    = (r_state == ST_OUT);
        o_cmd.load = (r_state == ST_IDLE) && i_valid;
        o_cmd.step = r_state;
    end

endmodule

// ===== sv/rlis_div.sv =====
// Restoring divider: 2^(2*FRAC_BITS) / sum, one quotient bit per cycle,
// saturated to 2^31-1. No dependencies.
`timescale 1ns / 1ps

module rlis_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_sum,
    output logic        o_done,
    output logic [31:0] o_quot
);
    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_num;
    logic [NB-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [32:0]   w_trial;

    assign w_trial = {r_rem[31:0], r_num[NB-1]};

    // shift in one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NB);
            r_num  <= {1'b1, {(NB-1){1'b0}}};
            r_q    <= '0;
            r_rem  <= '0;
            r_den  <= i_sum;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_q   <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[NB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy && !i_start;
    always_comb begin
        if (r_den == 32'd0 || r_q > NB'(32'h7FFF_FFFF)) begin
            o_quot = 32'h7FFF_FFFF;
        end else begin
            o_quot = r_q[31:0];
        end
    end

endmodule

// ===== sv/rlis_dp.sv =====
// Datapath of the rotary limit impulse solver: config registers, joint state,
// one shared multiplier, divider. Depends on rlis_pkg, rlis_div.
`timescale 1ns / 1ps

module rlis_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_operation,
    input  logic signed [31:0] i_angle_a,
    input  logic signed [31:0] i_angle_b,
    input  logic [30:0]        i_inv_moment_a,
    input  logic [30:0]        i_inv_moment_b,
    input  logic signed [31:0] i_ang_vel_a,
    input  logic signed [31:0] i_ang_vel_b,
    input  logic [30:0]        i_time_step,
    input  logic [30:0]        i_inv_time_step,
    input  rlis_pkg::t_cmd     i_cmd,
    output rlis_pkg::t_status  o_status,
    output logic signed [31:0] o_new_ang_vel_a,
    output logic signed [31:0] o_new_ang_vel_b,
    output logic [30:0]        o_impulse_magnitude
);
    import rlis_pkg::*;

    localparam logic signed [33:0] SMAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SMIN = -34'sh0_8000_0000;

    // config
    logic signed [31:0] r_min_angle, r_max_angle;
    logic [16:0] r_bias_coef;
    logic [30:0] r_max_bias, r_max_force;
    // joint state
    logic signed [31:0] r_isi, r_bias, r_limit, r_acc;
    // item latch
    logic        r_op;
    logic signed [31:0] r_ang_a, r_ang_b, r_va, r_vb;
    logic [30:0] r_ima, r_imb, r_dt, r_idt;
    // work registers
    logic signed [31:0] r_pdist;
    logic signed [32:0] r_j;
    logic signed [63:0] r_prod;
    // multiplier operands
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_full;
    logic signed [63:0] w_sh;      // shifted product, not saturated
    logic signed [33:0] w_fm;      // saturated shifted product
    logic signed [31:0] w_bwr;     // bias plus relative velocity
    logic               w_div_start, w_div_done;
    logic [31:0]        w_div_q;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > SMAX) return 32'sh7FFF_FFFF;
        if (v < SMIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // the shared multiplier: registered product of the current step
    assign w_full = w_ma * w_mb;
    assign w_bwr  = sat34(34'(r_bias) + 34'(sat34(34'(r_vb) - 34'(r_va))));

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.step)
            ST_PRE_DIST: begin
                w_ma = {16'd0, r_bias_coef};
                w_mb = {2'b0, r_idt};
            end
            ST_PRE_K: begin
                w_ma = w_fm[32:0];
                w_mb = {r_pdist[31], r_pdist};
            end
            ST_PRE_BIAS: begin
                w_ma = {2'b0, r_max_force};
                w_mb = {2'b0, r_dt};
            end
            ST_IT_WR: begin
                w_ma = 33'(w_bwr);
                w_mb = {r_isi[31], r_isi};
            end
            ST_VEL_A: begin
                w_ma = r_j;
                w_mb = {2'b0, r_ima};
            end
            ST_VEL_B: begin
                w_ma = r_j;
                w_mb = {2'b0, r_imb};
            end
            default: ;
        endcase
    end

    assign w_sh = r_prod >>> FRAC_BITS;
    assign w_fm = 34'(sat64(w_sh));

    // reciprocal of inertia sum
    assign w_div_start = (i_cmd.step == ST_PRE_DIST);
    rlis_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   ({1'b0, r_ima} + {1'b0, r_imb}),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle <= '0;
            r_max_angle <= '0;
            r_bias_coef <= '0;
            r_max_bias  <= 31'h7FFF_FFFF;
            r_max_force <= 31'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_ANGLE: r_min_angle <= i_cfg_data;
                CFG_MAX_ANGLE: r_max_angle <= i_cfg_data;
                CFG_BIAS_COEF: r_bias_coef <= i_cfg_data[16:0];
                CFG_MAX_BIAS:  r_max_bias  <= i_cfg_data[30:0];
                CFG_MAX_FORCE: r_max_force <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // datapath steps
    logic signed [31:0] w_sep, w_bias, w_jn, w_newacc;
    logic signed [33:0] w_sum;
    logic signed [33:0] w_negk;
    logic signed [33:0] w_cap;
    always_comb begin
        w_sep  = sat34(34'(r_ang_b) - 34'(r_ang_a));
        w_negk = -w_fm;
        w_cap  = {3'b0, r_max_bias};
        if (w_negk > w_cap) w_bias = {1'b0, r_max_bias};
        else if (w_negk < -w_cap) w_bias = -{1'b0, r_max_bias};
        else w_bias = w_negk[31:0];
        w_jn  = sat34(-w_fm);
        w_sum = 34'(r_acc) + 34'(w_jn);
        if (r_bias < 0) begin
            if (w_sum < 0) w_newacc = '0;
            else if (w_sum > 34'(r_limit)) w_newacc = r_limit;
            else w_newacc = w_sum[31:0];
        end else begin
            if (w_sum < -34'(r_limit)) w_newacc = -r_limit;
            else if (w_sum > 0) w_newacc = '0;
            else w_newacc = w_sum[31:0];
        end
    end

    // velocity b lands in the cycle after its product step
    logic r_vb_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb_pend <= 1'b0;
        end else begin
            r_vb_pend <= (i_cmd.step == ST_VEL_B);
        end
    end

    logic signed [31:0] w_vb_out;
    assign w_vb_out = sat64(64'(r_vb) + w_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isi   <= '0;
            r_bias  <= '0;
            r_limit <= '0;
            r_acc   <= '0;
        end else begin
            r_prod <= w_full[63:0];
            unique case (i_cmd.step)
                ST_IDLE: begin
                    if (i_cmd.load) begin
                        r_op    <= i_operation;
                        r_ang_a <= i_angle_a;
                        r_ang_b <= i_angle_b;
                        r_ima   <= i_inv_moment_a;
                        r_imb   <= i_inv_moment_b;
                        r_va    <= i_ang_vel_a;
                        r_vb    <= i_ang_vel_b;
                        r_dt    <= i_time_step;
                        r_idt   <= i_inv_time_step;
                    end
                end
                ST_PRE_DIST: begin
                    if (w_sep > r_max_angle)
                        r_pdist <= sat34(34'(r_max_angle) - 34'(w_sep));
                    else if (w_sep < r_min_angle)
                        r_pdist <= sat34(34'(r_min_angle) - 34'(w_sep));
                    else
                        r_pdist <= '0;
                end
                ST_PRE_BIAS: r_bias <= w_bias;
                ST_PRE_LIMIT: begin
                    r_limit <= w_fm[31:0];
                    if (r_bias == 0) r_acc <= '0;
                end
                ST_DIV_WAIT: begin
                    r_isi <= w_div_q;
                    r_j   <= 33'(r_acc);
                end
                ST_IT_J: begin
                    r_acc <= w_newacc;
                    r_j   <= 33'(34'(w_newacc) - 34'(r_acc));
                end
                ST_VEL_B: r_va <= sat64(64'(r_va) - w_sh);
                default: ;
            endcase
            // hold velocity b once its product has landed
            if (r_vb_pend) r_vb <= w_vb_out;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.prestep  = (i_operation == 1'(OP_PRESTEP));
    assign o_status.skip     = (r_bias == 0) && (r_op == 1'(OP_IMPULSE));

    assign o_new_ang_vel_a = r_va;
    assign o_new_ang_vel_b = r_vb_pend ? w_vb_out : r_vb;
    assign o_impulse_magnitude = (r_acc == 32'sh8000_0000) ? 31'h7FFF_FFFF :
                                 (r_acc < 0 ? 31'(-r_acc) : r_acc[30:0]);

endmodule

// ===== sim/rotary_limit_impulse_solver_test.sv =====
// Self-checking test of the rotary limit impulse solver: prestep and impulse
// beats against an in-bench fixed point predictor. Depends on rlis_pkg and the RTL.
`timescale 1ns / 1ps

module rotary_limit_impulse_solver_test;
    import rlis_pkg::*;

    localparam int FB = 16;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic signed [31:0] i_angle_a = '0;
    logic signed [31:0] i_angle_b = '0;
    logic [30:0]        i_inv_moment_a = '0;
    logic [30:0]        i_inv_moment_b = '0;
    logic signed [31:0] i_ang_vel_a = '0;
    logic signed [31:0] i_ang_vel_b = '0;
    logic [30:0]        i_time_step = '0;
    logic [30:0]        i_inv_time_step = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_new_ang_vel_a;
    logic signed [31:0] o_new_ang_vel_b;
    logic [30:0]        o_impulse_magnitude;

    rotary_limit_impulse_solver dut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct {
        logic signed [31:0] vel_a;
        logic signed [31:0] vel_b;
        logic [30:0]        mag;
    } t_solution;

    t_solution solution_q[$];
    int        error_count = 0;
    bit        hold_off = 1'b0;

    // predictor registers and state
    longint lim_lo, lim_hi, coef, bias_cap, force_cap;
    longint inv_inertia, bias_vel, imp_limit, acc_imp;

    function automatic longint sat32(longint v);
        if (v > S32MAX) return S32MAX;
        if (v < S32MIN) return S32MIN;
        return v;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // arithmetic shift floors toward minus infinity
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FB;
    endfunction

    task automatic solve_beat(input bit op, input longint ang_a, input longint ang_b,
                              input longint im_a, input longint im_b,
                              input longint va_in, input longint vb_in,
                              input longint dt, input longint idt);
        longint sep, pdist, sum, k, va, vb, wr, j, prev, mag;
        t_solution s;
        va = va_in;
        vb = vb_in;
        if (op == OP_PRESTEP[0]) begin
            sep = sat32(ang_b - ang_a);
            pdist = 0;
            if (sep > lim_hi) pdist = sat32(lim_hi - sep);
            else if (sep < lim_lo) pdist = sat32(lim_lo - sep);
            sum = im_a + im_b;
            if (sum == 0) inv_inertia = S32MAX;
            else inv_inertia = clamp((64'sd1 << (2 * FB)) / sum, 0, S32MAX);
            k = sat32(qmul(coef, idt));
            bias_vel = clamp(-sat32(qmul(k, pdist)), -bias_cap, bias_cap);
            imp_limit = sat32(qmul(force_cap, dt));
            if (bias_vel == 0) acc_imp = 0;
            va = sat32(va - qmul(acc_imp, im_a));
            vb = sat32(vb + qmul(acc_imp, im_b));
        end else if (bias_vel != 0) begin
            wr = sat32(vb - va);
            j = sat32(-sat32(qmul(sat32(bias_vel + wr), inv_inertia)));
            prev = acc_imp;
            if (bias_vel < 0) acc_imp = clamp(prev + j, 0, imp_limit);
            else acc_imp = clamp(prev + j, -imp_limit, 0);
            j = acc_imp - prev;
            va = sat32(va - qmul(j, im_a));
            vb = sat32(vb + qmul(j, im_b));
        end
        mag = acc_imp < 0 ? -acc_imp : acc_imp;
        if (mag > S32MAX) mag = S32MAX;
        s.vel_a = va[31:0];
        s.vel_b = vb[31:0];
        s.mag = mag[30:0];
        solution_q.push_back(s);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // send one beat with a random gap before it; valid stays up until the next gap
    task automatic send_beat(input bit op, input logic [31:0] aa, input logic [31:0] ab,
                             input logic [30:0] ma, input logic [30:0] mb,
                             input logic [31:0] va, input logic [31:0] vb,
                             input logic [30:0] dt, input logic [30:0] idt);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_angle_a <= aa;
        i_angle_b <= ab;
        i_inv_moment_a <= ma;
        i_inv_moment_b <= mb;
        i_ang_vel_a <= va;
        i_ang_vel_b <= vb;
        i_time_step <= dt;
        i_inv_time_step <= idt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        solve_beat(op, $signed(aa), $signed(ab), ma, mb, $signed(va), $signed(vb), dt, idt);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (solution_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_ANGLE: lim_lo = $signed(val);
            CFG_MAX_ANGLE: lim_hi = $signed(val);
            CFG_BIAS_COEF: coef = val[16:0];
            CFG_MAX_BIAS:  bias_cap = val[30:0];
            CFG_MAX_FORCE: force_cap = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [16:0] c, input logic [30:0] mb,
                              input logic [30:0] mf);
        drain();
        write_reg(CFG_MIN_ANGLE, lo);
        write_reg(CFG_MAX_ANGLE, hi);
        write_reg(CFG_BIAS_COEF, {15'd0, c});
        write_reg(CFG_MAX_BIAS, {1'b0, mb});
        write_reg(CFG_MAX_FORCE, {1'b0, mf});
        i_cfg_we <= 1'b0;
    endtask

    // small random quantity, mostly moderate Q16.16 magnitudes
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] rnd_pos();
        case ($urandom_range(0, 5))
            0: return 31'($urandom);
            1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0;
            default: return 31'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    task automatic send_random(input bit op);
        send_beat(op, rnd_word(), rnd_word(), rnd_pos(), rnd_pos(), rnd_word(), rnd_word(),
                  rnd_pos(), rnd_pos());
    endtask

    // extremes of each field, zero inertia, zero bias, reversed limits
    task automatic test_directed();
        set_config(-32'sd65536, 32'sd65536, 17'd13107, 31'h7fff_ffff, 31'h7fff_ffff);
        send_beat(OP_IMPULSE[0], '0, '0, '0, '0, 32'h1234, 32'h4321, '0, '0);
        send_beat(OP_PRESTEP[0], '0, '0, '0, '0, '0, '0, 31'd1092, 31'd3932160);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd65536, 31'd65536, 32'h10000, '0, '0, '0);
        send_beat(OP_PRESTEP[0], 32'h8000_0000, 32'h7fff_ffff, 31'd65536, 31'd65536,
                  32'h7fff_ffff, 32'h8000_0000, 31'd1092, 31'd3932160);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd65536, 31'd65536, 32'h7fff_ffff, 32'h8000_0000,
                  '0, '0);
        send_beat(OP_IMPULSE[0], '0, '0, 31'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, '0, '0);
        send_beat(OP_PRESTEP[0], 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
                  31'h7fff_ffff, 32'hffff_ffff, 32'h1, 31'h7fff_ffff, 31'h7fff_ffff);
        send_beat(OP_IMPULSE[0], 32'hffff_ffff, 32'hffff_ffff, 31'd1, 31'd0, 32'h5555_5555,
                  32'haaaa_aaaa, 31'h7fff_ffff, 31'h7fff_ffff);
        send_beat(OP_PRESTEP[0], '0, 32'h0002_0000, 31'd1, 31'd0, '0, '0, 31'd1, 31'd1);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd1, 31'd0, 32'h0001_0000, '0, '0, '0);
        send_beat(OP_PRESTEP[0], '0, 32'h0000_8000, 31'd100, 31'd200, 32'h100, 32'h200,
                  31'd1092, 31'd3932160);
        set_config(32'sd65536, -32'sd65536, 17'd65536, 31'd0, 31'd0);
        send_beat(OP_PRESTEP[0], '0, '0, 31'd65536, 31'd1, 32'h100, 32'h200, 31'd1092,
                  31'd60);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd65536, 31'd1, 32'h100, 32'h200, '0, '0);
        set_config(32'sd65536, -32'sd65536, 17'd65536, 31'h7fff_ffff, 31'd1000);
        send_beat(OP_PRESTEP[0], '0, '0, 31'd65536, 31'd1, 32'h100, 32'h200, 31'd1092,
                  31'd60);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd65536, 31'd1, 32'h100, 32'h200, '0, '0);
        send_beat(OP_PRESTEP[0], '0, 32'h0003_0000, 31'd65536, 31'd1, 32'h100, 32'h200,
                  31'd1092, 31'd60);
        send_beat(OP_IMPULSE[0], '0, '0, 31'd65536, 31'd1, 32'h100, 32'h200, '0, '0);
    endtask

    // mostly well-formed steps: one prestep followed by several iterations; now and then a lone random beat
    task automatic test_random_steps(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_random(1'($urandom_range(0, 1)));
                n++;
            end else begin
                send_random(OP_PRESTEP[0]);
                n++;
                repeat ($urandom_range(1, 8)) begin
                    send_random(OP_IMPULSE[0]);
                    n++;
                end
            end
        end
    endtask

    // hold the result side off so the block backs up
    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (6) send_random(OP_IMPULSE[0]);
        drain();
        send_random(OP_PRESTEP[0]);
        repeat (4) send_random(OP_IMPULSE[0]);
    endtask

    task automatic test_configs();
        set_config(32'h8000_0000, 32'h7fff_ffff, 17'd0, 31'h7fff_ffff, 31'h7fff_ffff);
        test_random_steps(150);
        set_config(-32'sd32768, 32'sd32768, 17'd65536, 31'd1, 31'h7fff_ffff);
        test_random_steps(150);
        set_config($urandom, $urandom, 17'($urandom_range(0, 65536)), 31'($urandom),
                   31'($urandom));
        test_random_steps(150);
        set_config(32'h7fff_ffff, 32'h8000_0000, 17'd65536, 31'h7fff_ffff, 31'd1);
        test_random_steps(150);
    endtask

    initial begin
        lim_lo = 0; lim_hi = 0; coef = 0; bias_cap = S32MAX; force_cap = S32MAX;
        inv_inertia = 0; bias_vel = 0; imp_limit = 0; acc_imp = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        set_config(-32'sd65536, 32'sd65536, 17'd13107, 31'h0100_0000, 31'h0100_0000);
        test_random_steps(1400);
        test_configs();
        drain();
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int wait_cycles;
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end
            wait_cycles = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // compare every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_solution s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (solution_q.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                error_count++;
            end else begin
                s = solution_q.pop_front();
                if (o_new_ang_vel_a !== s.vel_a) report("new_ang_vel_a", o_new_ang_vel_a, s.vel_a);
                if (o_new_ang_vel_b !== s.vel_b) report("new_ang_vel_b", o_new_ang_vel_b, s.vel_b);
                if (o_impulse_magnitude !== s.mag)
                    report("impulse_magnitude", o_impulse_magnitude, s.mag);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rlis_pkg.sv
sv/rlis_ctrl.sv
sv/rlis_div.sv
sv/rlis_dp.sv
sv/rotary_limit_impulse_solver.sv
sim/rotary_limit_impulse_solver_test.sv
